[src/tclp_pkg.sv]
// Package with the shared types and constants of the text command line parser.
package tclp_pkg;

  typedef enum logic [2:0] {
    KIND_FWD   = 3'd0,
    KIND_BACK  = 3'd1,
    KIND_HIGH  = 3'd2,
    KIND_LOW   = 3'd3,
    KIND_MODE  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_STEPS     = 3'd2,
    ST_TYPE_WORD = 3'd3,
    ST_DELAY     = 3'd4,
    ST_MODE      = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN,
    S_WORD,
    S_TSKIP,
    S_TYPE,
    S_NSKIP,
    S_SIGN,
    S_DIGIT,
    S_TRAIL,
    S_DONE,
    S_OUT
  } state_e;

  // Command being tried: the four patterns in their order of precedence.
  typedef enum logic [1:0] {
    CMD_FWD   = 2'd0,
    CMD_BACK  = 2'd1,
    CMD_DELAY = 2'd2,
    CMD_MODE  = 2'd3
  } cmd_e;

  localparam logic [7:0] ChCr  = 8'd13;
  localparam logic [7:0] ChLf  = 8'd10;
  localparam logic [7:0] ChBs  = 8'd8;
  localparam logic [7:0] ChDel = 8'd127;

  localparam logic [31:0] StepMax  = 32'd2000;
  localparam logic [31:0] DelayMax = 32'd1000000;
  localparam int unsigned TypeMax  = 7;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [7:0] word_char(input cmd_e cmd, input logic [2:0] i);
    logic [7:0] ch;
    ch = 8'd0;
    case (cmd)
      CMD_FWD: begin
        case (i)
          3'd0: ch = "f";
          3'd1: ch = "w";
          3'd2: ch = "d";
          default: ch = 8'd0;
        endcase
      end
      CMD_BACK: begin
        case (i)
          3'd0: ch = "b";
          3'd1: ch = "a";
          3'd2: ch = "c";
          3'd3: ch = "k";
          default: ch = 8'd0;
        endcase
      end
      CMD_DELAY: begin
        case (i)
          3'd0: ch = "d";
          3'd1: ch = "e";
          3'd2: ch = "l";
          3'd3: ch = "a";
          3'd4: ch = "y";
          default: ch = 8'd0;
        endcase
      end
      CMD_MODE: begin
        case (i)
          3'd0: ch = "m";
          3'd1: ch = "o";
          3'd2: ch = "d";
          3'd3: ch = "e";
          default: ch = 8'd0;
        endcase
      end
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] word_len(input cmd_e cmd);
    logic [2:0] n;
    case (cmd)
      CMD_FWD:   n = 3'd3;
      CMD_BACK:  n = 3'd4;
      CMD_DELAY: n = 3'd5;
      CMD_MODE:  n = 3'd4;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

[src/tclp_ram.sv]
// Generic RAM with one write port and one registered read port.
module tclp_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/text_command_line_parser.sv]
// Top level of the text command line parser.
// Ordinary bytes, deletes and line ends on an empty line are taken back to back.
// A line end on a stored line first measures the line, then walks the bytes one a cycle
// through the line RAM's registered read port, trying the patterns in turn; no request is
// taken meanwhile.
// A result waits in its own output register; reset clears the fill count, the sequencer
// and the result valid, and the line RAM is not cleared.
module text_command_line_parser #(
  parameter int LINE_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        char_code_valid_i,
  output logic        char_code_stall_o,
  input  logic [7:0]  char_code_i,
  output logic        result_valid_o,
  input  logic        result_stall_i,
  output logic [2:0]  cmd_kind_o,
  output logic [31:0] arg_value_o,
  output logic [2:0]  status_o
);

  localparam int AW = $clog2(LINE_BYTES);
  localparam int CW = $clog2(LINE_BYTES + 1);
  localparam logic [CW-1:0] FillMax = CW'(LINE_BYTES - 1);

  tclp_pkg::state_e state_q, state_d;
  tclp_pkg::cmd_e   cmd_q, cmd_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [CW-1:0]    len_q, len_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [31:0]      acc_q, acc_d;
  logic             neg_q, neg_d;
  logic             hi_q, hi_d;
  logic             lo_q, lo_d;
  logic             out_valid_q, out_valid_d;
  logic [2:0]       kind_q, kind_d;
  logic [31:0]      val_q, val_d;
  logic [2:0]       stat_q, stat_d;
  logic [2:0]       res_kind_q, res_kind_d;
  logic [31:0]      res_val_q, res_val_d;
  logic [2:0]       res_stat_q, res_stat_d;

  logic             accept;
  logic [7:0]       rdata;
  logic             ram_we;
  logic [AW-1:0]    raddr;
  logic             at_end;
  logic [7:0]       ch;
  logic [31:0]      acc_x10;
  logic [31:0]      sval;
  logic             res_free;

  assign accept = char_code_valid_i && !char_code_stall_o;
  assign char_code_stall_o = (state_q != tclp_pkg::S_IDLE);
  assign res_free = !out_valid_q || !result_stall_i;
  assign ram_we = accept && (char_code_i != tclp_pkg::ChCr) &&
                  (char_code_i != tclp_pkg::ChLf) && (char_code_i != tclp_pkg::ChBs) &&
                  (char_code_i != tclp_pkg::ChDel) && (fill_q < FillMax);

  // The read address runs one step ahead of the position under test.
  assign raddr = pos_d[AW-1:0];
  assign ch = rdata;
  assign at_end = (pos_q >= len_q);
  assign acc_x10 = (acc_q << 3) + (acc_q << 1);
  assign sval = neg_q ? (32'd0 - acc_q) : acc_q;

  tclp_ram #(
    .Width(8),
    .Depth(LINE_BYTES)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(fill_q[AW-1:0]),
    .wdata_i(char_code_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tclp_pkg::S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    len_q      <= len_d;
    pos_q      <= pos_d;
    cnt_q      <= cnt_d;
    acc_q      <= acc_d;
    neg_q      <= neg_d;
    hi_q       <= hi_d;
    lo_q       <= lo_d;
    kind_q     <= kind_d;
    val_q      <= val_d;
    stat_q     <= stat_d;
    res_kind_q <= res_kind_d;
    res_val_q  <= res_val_d;
    res_stat_q <= res_stat_d;
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tclp_pkg::S_IDLE: begin
        if (accept && (char_code_i == tclp_pkg::ChCr || char_code_i == tclp_pkg::ChLf) &&
            fill_q != '0) begin
          state_d = tclp_pkg::S_LEN;
        end
      end
      tclp_pkg::S_LEN: begin
        if (pos_q >= fill_q || ch == 8'd0) begin
          state_d = tclp_pkg::S_WORD;
        end
      end
      tclp_pkg::S_WORD: begin
        if (cnt_q == tclp_pkg::word_len(cmd_q)) begin
          state_d = (cmd_q == tclp_pkg::CMD_DELAY) ? tclp_pkg::S_TSKIP : tclp_pkg::S_NSKIP;
        end else if (at_end || ch != tclp_pkg::word_char(cmd_q, cnt_q)) begin
          state_d = (cmd_q == tclp_pkg::CMD_MODE) ? tclp_pkg::S_DONE : tclp_pkg::S_WORD;
        end
      end
      tclp_pkg::S_TSKIP: begin
        if (at_end || !tclp_pkg::is_blank(ch)) begin
          state_d = tclp_pkg::S_TYPE;
        end
      end
      tclp_pkg::S_TYPE: begin
        if (at_end || tclp_pkg::is_blank(ch) || cnt_q == 3'(tclp_pkg::TypeMax)) begin
          state_d = (cnt_q == 3'd0) ? tclp_pkg::S_WORD : tclp_pkg::S_NSKIP;
        end
      end
      tclp_pkg::S_NSKIP: begin
        if (at_end || !tclp_pkg::is_blank(ch)) begin
          state_d = tclp_pkg::S_SIGN;
        end
      end
      tclp_pkg::S_SIGN: begin
        state_d = tclp_pkg::S_DIGIT;
      end
      tclp_pkg::S_DIGIT: begin
        if (at_end || ch < "0" || ch > "9") begin
          if (cnt_q != 3'd0) begin
            state_d = tclp_pkg::S_TRAIL;
          end else if (cmd_q == tclp_pkg::CMD_MODE) begin
            state_d = tclp_pkg::S_DONE;
          end else begin
            state_d = tclp_pkg::S_WORD;
          end
        end
      end
      tclp_pkg::S_TRAIL: begin
        if (at_end || !tclp_pkg::is_blank(ch)) begin
          state_d = tclp_pkg::S_DONE;
        end
      end
      tclp_pkg::S_DONE: begin
        state_d = tclp_pkg::S_OUT;
      end
      tclp_pkg::S_OUT: begin
        if (res_free) begin
          state_d = tclp_pkg::S_IDLE;
        end
      end
      default: state_d = tclp_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    fill_d      = fill_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    out_valid_d = out_valid_q && result_stall_i;
    kind_d      = kind_q;
    val_d       = val_q;
    stat_d      = stat_q;
    res_kind_d  = res_kind_q;
    res_val_d   = res_val_q;
    res_stat_d  = res_stat_q;
    case (state_q)
      tclp_pkg::S_IDLE: begin
        pos_d = '0;
        if (accept) begin
          if (char_code_i == tclp_pkg::ChCr || char_code_i == tclp_pkg::ChLf) begin
            len_d = '0;
          end else if (char_code_i == tclp_pkg::ChBs || char_code_i == tclp_pkg::ChDel) begin
            if (fill_q != '0) begin
              fill_d = fill_q - CW'(1);
            end
          end else if (fill_q < FillMax) begin
            fill_d = fill_q + CW'(1);
          end
        end
      end
      tclp_pkg::S_LEN: begin
        if (pos_q >= fill_q || ch == 8'd0) begin
          len_d = pos_q;
          pos_d = '0;
          cmd_d = tclp_pkg::CMD_FWD;
          cnt_d = 3'd0;
        end else begin
          pos_d = pos_q + CW'(1);
        end
      end
      tclp_pkg::S_WORD: begin
        if (cnt_q == tclp_pkg::word_len(cmd_q)) begin
          cnt_d = 3'd0;
          hi_d  = 1'b0;
          lo_d  = 1'b0;
          acc_d = '0;
          neg_d = 1'b0;
        end else if (at_end || ch != tclp_pkg::word_char(cmd_q, cnt_q)) begin
          cmd_d  = tclp_pkg::cmd_e'(cmd_q + 2'd1);
          cnt_d  = 3'd0;
          pos_d  = '0;
          kind_d = tclp_pkg::KIND_FWD;
          val_d  = '0;
          stat_d = tclp_pkg::ST_INVALID;
        end else begin
          cnt_d = cnt_q + 3'd1;
          pos_d = pos_q + CW'(1);
        end
      end
      tclp_pkg::S_TSKIP, tclp_pkg::S_NSKIP, tclp_pkg::S_TRAIL: begin
        if (!at_end && tclp_pkg::is_blank(ch)) begin
          pos_d = pos_q + CW'(1);
        end
      end
      tclp_pkg::S_TYPE: begin
        if (at_end || tclp_pkg::is_blank(ch) || cnt_q == 3'(tclp_pkg::TypeMax)) begin
          hi_d  = hi_q && cnt_q == 3'd4;
          lo_d  = lo_q && cnt_q == 3'd3;
          cnt_d = 3'd0;
          if (cnt_q == 3'd0) begin
            cmd_d = tclp_pkg::CMD_MODE;
            pos_d = '0;
          end
        end else begin
          case (cnt_q)
            3'd0: begin
              hi_d = ch == "h";
              lo_d = ch == "l";
            end
            3'd1: begin
              hi_d = hi_q && ch == "i";
              lo_d = lo_q && ch == "o";
            end
            3'd2: begin
              hi_d = hi_q && ch == "g";
              lo_d = lo_q && ch == "w";
            end
            3'd3: hi_d = hi_q && ch == "h";
            default: begin
            end
          endcase
          cnt_d = cnt_q + 3'd1;
          pos_d = pos_q + CW'(1);
        end
      end
      tclp_pkg::S_SIGN: begin
        if (!at_end && (ch == "+" || ch == "-")) begin
          neg_d = ch == "-";
          pos_d = pos_q + CW'(1);
        end
      end
      tclp_pkg::S_DIGIT: begin
        if (at_end || ch < "0" || ch > "9") begin
          if (cnt_q == 3'd0) begin
            cmd_d  = tclp_pkg::cmd_e'(cmd_q + 2'd1);
            pos_d  = '0;
            kind_d = tclp_pkg::KIND_FWD;
            val_d  = '0;
            stat_d = tclp_pkg::ST_INVALID;
          end
        end else begin
          acc_d = acc_x10 + {28'd0, ch[3:0] - 4'd0};
          cnt_d = 3'd1;
          pos_d = pos_q + CW'(1);
        end
      end
      tclp_pkg::S_DONE: begin
        if (stat_q == tclp_pkg::ST_INVALID && state_q == tclp_pkg::S_DONE &&
            cnt_q == 3'd0) begin
          kind_d = tclp_pkg::KIND_FWD;
          val_d  = '0;
        end else if (!at_end) begin
          kind_d = tclp_pkg::KIND_FWD;
          val_d  = '0;
          stat_d = tclp_pkg::ST_INVALID;
        end else begin
          val_d = sval;
          case (cmd_q)
            tclp_pkg::CMD_FWD, tclp_pkg::CMD_BACK: begin
              kind_d = (cmd_q == tclp_pkg::CMD_FWD) ? tclp_pkg::KIND_FWD : tclp_pkg::KIND_BACK;
              stat_d = ($signed(sval) < 0 || $signed(sval) > $signed(tclp_pkg::StepMax)) ?
                       tclp_pkg::ST_STEPS : tclp_pkg::ST_OK;
            end
            tclp_pkg::CMD_DELAY: begin
              if (!hi_q && !lo_q) begin
                kind_d = tclp_pkg::KIND_HIGH;
                stat_d = tclp_pkg::ST_TYPE_WORD;
              end else begin
                kind_d = hi_q ? tclp_pkg::KIND_HIGH : tclp_pkg::KIND_LOW;
                stat_d = ($signed(sval) < 0 || $signed(sval) > $signed(tclp_pkg::DelayMax)) ?
                         tclp_pkg::ST_DELAY : tclp_pkg::ST_OK;
              end
            end
            default: begin
              kind_d = tclp_pkg::KIND_MODE;
              stat_d = (sval == 32'd1 || sval == 32'd2 || sval == 32'd4 || sval == 32'd8 ||
                        sval == 32'd16 || sval == 32'd32) ? tclp_pkg::ST_OK : tclp_pkg::ST_MODE;
            end
          endcase
        end
      end
      tclp_pkg::S_OUT: begin
        if (res_free) begin
          out_valid_d = 1'b1;
          res_kind_d  = kind_q;
          res_val_d   = val_q;
          res_stat_d  = stat_q;
          fill_d      = '0;
          pos_d       = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign result_valid_o = out_valid_q;
  assign cmd_kind_o     = res_kind_q;
  assign arg_value_o    = res_val_q;
  assign status_o       = res_stat_q;

`ifndef NO_ASSERTIONS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != tclp_pkg::S_IDLE) |-> char_code_stall_o)
    else $error("input taken while a line is parsed");
  a_out_clears_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tclp_pkg::S_OUT && res_free) |=> (fill_q == '0 && result_valid_o))
    else $error("line not cleared on result");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillMax)
    else $error("fill count beyond line size");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_stall_i) |=>
    (result_valid_o && $stable(cmd_kind_o) && $stable(arg_value_o) && $stable(status_o)))
    else $error("stalled result changed");
`endif

endmodule

[sim/tb.sv]
// Testbench for the text command line parser: directed and random command lines checked
// against a behavioral line parser.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [2:0]  st;
  } cmd_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        char_code_valid_i;
  logic        char_code_stall_o;
  logic [7:0]  char_code_i;
  logic        result_valid_o;
  logic        result_stall_i;
  logic [2:0]  cmd_kind_o;
  logic [31:0] arg_value_o;
  logic [2:0]  status_o;

  logic [7:0]  line_buf [32];
  int          line_fill;
  cmd_result_t pending_q[$];
  int          mismatches;
  int          idle_cycles;
  int          send_idle_pct;
  int          stall_pct;
  int          hold_off;

  text_command_line_parser i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .char_code_valid_i(char_code_valid_i), .char_code_stall_o(char_code_stall_o),
    .char_code_i(char_code_i),
    .result_valid_o(result_valid_o), .result_stall_i(result_stall_i),
    .cmd_kind_o(cmd_kind_o), .arg_value_o(arg_value_o), .status_o(status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic blank_ch(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic int skip_blanks(int p, int n);
    while (p < n && blank_ch(line_buf[p])) p++;
    return p;
  endfunction

  function automatic logic word_at(inout int p, input string w, input int n);
    int q;
    q = p;
    for (int i = 0; i < w.len(); i++) begin
      if (q >= n || line_buf[q] != w[i]) return 1'b0;
      q++;
    end
    p = q;
    return 1'b1;
  endfunction

  function automatic logic read_number(inout int p, output logic [31:0] v, input int n);
    int q;
    logic neg;
    logic [31:0] acc;
    int digits;
    q = skip_blanks(p, n);
    neg = 1'b0;
    acc = '0;
    digits = 0;
    v = '0;
    if (q < n && (line_buf[q] == "+" || line_buf[q] == "-")) begin
      neg = line_buf[q] == "-";
      q++;
    end
    while (q < n && line_buf[q] >= "0" && line_buf[q] <= "9") begin
      acc = acc * 32'd10 + 32'(line_buf[q] - "0");
      q++;
      digits++;
    end
    if (digits == 0) return 1'b0;
    v = neg ? -acc : acc;
    p = q;
    return 1'b1;
  endfunction

  function automatic cmd_result_t parse_command(int n);
    cmd_result_t r;
    int p, q, start, wl;
    logic [31:0] v;
    logic hi, lo;
    string words[2];
    words[0] = "fwd";
    words[1] = "back";
    r = '{tclp_pkg::KIND_FWD, 32'd0, tclp_pkg::ST_INVALID};
    for (int k = 0; k < 2; k++) begin
      p = 0;
      if (word_at(p, words[k], n) && read_number(p, v, n)) begin
        if (skip_blanks(p, n) < n) return r;
        r.kind = (k == 0) ? tclp_pkg::KIND_FWD : tclp_pkg::KIND_BACK;
        r.value = v;
        r.st = ($signed(v) < 0 || $signed(v) > 2000) ? tclp_pkg::ST_STEPS : tclp_pkg::ST_OK;
        return r;
      end
    end
    p = 0;
    if (word_at(p, "delay", n)) begin
      q = skip_blanks(p, n);
      start = q;
      wl = 0;
      while (q < n && !blank_ch(line_buf[q]) && wl < 7) begin
        q++;
        wl++;
      end
      if (wl > 0 && read_number(q, v, n)) begin
        hi = wl == 4 && line_buf[start] == "h" && line_buf[start+1] == "i" &&
             line_buf[start+2] == "g" && line_buf[start+3] == "h";
        lo = wl == 3 && line_buf[start] == "l" && line_buf[start+1] == "o" &&
             line_buf[start+2] == "w";
        if (skip_blanks(q, n) < n) return r;
        r.value = v;
        if (!hi && !lo) begin
          r.kind = tclp_pkg::KIND_HIGH;
          r.st = tclp_pkg::ST_TYPE_WORD;
        end else begin
          r.kind = hi ? tclp_pkg::KIND_HIGH : tclp_pkg::KIND_LOW;
          r.st = ($signed(v) < 0 || $signed(v) > 1000000) ? tclp_pkg::ST_DELAY : tclp_pkg::ST_OK;
        end
        return r;
      end
    end
    p = 0;
    if (word_at(p, "mode", n) && read_number(p, v, n)) begin
      if (skip_blanks(p, n) < n) return r;
      r.kind = tclp_pkg::KIND_MODE;
      r.value = v;
      r.st = (v == 1 || v == 2 || v == 4 || v == 8 || v == 16 || v == 32) ?
             tclp_pkg::ST_OK : tclp_pkg::ST_MODE;
    end
    return r;
  endfunction

  function automatic void predict_char(logic [7:0] c);
    int n;
    if (c == tclp_pkg::ChCr || c == tclp_pkg::ChLf) begin
      if (line_fill == 0) return;
      n = 0;
      while (n < line_fill && line_buf[n] != 8'd0) n++;
      pending_q.push_back(parse_command(n));
      line_fill = 0;
    end else if (c == tclp_pkg::ChBs || c == tclp_pkg::ChDel) begin
      if (line_fill > 0) line_fill--;
    end else if (line_fill < 31) begin
      line_buf[line_fill] = c;
      line_fill++;
    end
  endfunction

  task automatic send_char(logic [7:0] c);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      char_code_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    char_code_valid_i <= 1'b1;
    char_code_i <= c;
    @(posedge clk_i);
    while (char_code_stall_o) @(posedge clk_i);
    predict_char(c);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_line(string s);
    send_text(s);
    send_char(($urandom_range(1) != 0) ? tclp_pkg::ChCr : tclp_pkg::ChLf);
  endtask

  task automatic drain();
    char_code_valid_i <= 1'b0;
    while (pending_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_line("fwd 0");
    send_line("fwd 2000");
    send_line("back 2001");
    send_line("back-1");
    send_line("fwd 4294967297");
    send_line("delay high 1000000");
    send_line("delay low 1000001");
    send_line("delay fast 5");
    send_line("delay abcdefghi 5");
    send_line("mode 32");
    send_line("mode 3 ");
    send_line("fwd 5 x");
    send_line(" fwd 5");
    send_line("hello");
    send_char(tclp_pkg::ChCr);
    send_char(tclp_pkg::ChBs);
    send_line("fwx\x7fd\x08d 12");
    send_line("mode +8\t");
    for (int i = 0; i < 40; i++) send_char("7");
    send_char(tclp_pkg::ChLf);
    send_char(8'd0);
    send_char(8'hff);
    send_char(tclp_pkg::ChLf);
    send_text("fwd 9");
    send_char(8'd0);
    send_line("zz");
    drain();
  endtask

  function automatic string random_number();
    string s;
    case ($urandom_range(5))
      0: s = $sformatf("%0d", $urandom_range(2100));
      1: s = $sformatf("%0d", $urandom_range(1100000));
      2: s = $sformatf("-%0d", $urandom_range(50));
      3: s = $sformatf("%0d", 1 << $urandom_range(6));
      4: s = $sformatf("%0d%0d", $urandom, $urandom_range(9));
      default: s = "";
    endcase
    return s;
  endfunction

  task automatic test_random(int n_chars);
    string words[6];
    string s;
    int sent;
    int w;
    words[0] = "fwd"; words[1] = "back"; words[2] = "delay high";
    words[3] = "delay low"; words[4] = "mode"; words[5] = "delay xyz";
    sent = 0;
    while (sent < n_chars) begin
      if ($urandom_range(9) < 8) begin
        w = $urandom_range(5);
        if ($urandom_range(3) != 0) s = {words[w], " ", random_number()};
        else s = {words[w], random_number()};
        if ($urandom_range(7) == 0) s = {s, " q"};
        else if ($urandom_range(3) == 0) s = {s, " "};
        if ($urandom_range(9) == 0) s = {s, "\x08"};
        send_line(s);
        sent += s.len() + 1;
      end else begin
        for (int i = $urandom_range(1, 12); i > 0; i--) begin
          send_char(8'($urandom));
          sent++;
        end
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 2000;
    send_idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < 15; i++) send_line("mode 4");
    drain();
  endtask

  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      result_stall_i <= 1'b1;
    end else begin
      result_stall_i <= stall_pct > 0 && $urandom_range(99) < stall_pct;
    end
  end

  always @(posedge clk_i) begin
    cmd_result_t exp;
    if (rst_ni && result_valid_o && !result_stall_i) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d %0d %0d",
                                       cmd_kind_o, arg_value_o, status_o);
      end else begin
        exp = pending_q.pop_front();
        if (exp.kind !== cmd_kind_o || exp.value !== arg_value_o || exp.st !== status_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     exp.kind, $signed(exp.value), exp.st,
                     cmd_kind_o, $signed(arg_value_o), status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((char_code_valid_i && !char_code_stall_o) || (result_valid_o && !result_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    char_code_valid_i = 1'b0;
    char_code_i = 8'd0;
    result_stall_i = 1'b0;
    line_fill = 0;
    mismatches = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(100);
    send_idle_pct = 80;
    test_random(90);
    send_idle_pct = 0;
    stall_pct = 80;
    test_random(90);
    send_idle_pct = 6;
    stall_pct = 6;
    test_random(90);
    test_backpressure();
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
